### src/pll_pkg.sv
// shared types, codes and defaults for the pooled linked list block
// used by pll_ctrl, pll_datapath and pooled_linked_list; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pll_pkg;

  // default sizing
  localparam int POOL_SIZE_DEF = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // fixed field widths
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;

  // operation codes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd4;

  // input request payload
  typedef struct packed {
    logic              operation;
    logic [ITEM_W-1:0] item_value;
  } in_t;

  // result payload
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
  } out_t;

  // which slot number goes with a result
  typedef enum logic [1:0] {
    RES_NONE,
    RES_SCAN,
    RES_CUR
  } res_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic                load;
    logic                scan_next;
    logic                add_write;
    logic                walk_next;
    logic                unlink;
    logic                set_res;
    logic [STATUS_W-1:0] res_status;
    res_sel_t            res_sel;
    logic                emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_op;
    logic in_key_zero;
    logic head_zero;
    logic scan_used;
    logic scan_last;
    logic match;
    logic link_zero;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### src/pll_datapath.sv
// datapath: head, slot used bits, slot key and link memories, result register
// depends on pll_pkg; driven by pll_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module pll_datapath #(
  parameter int POOL_SIZE = pll_pkg::POOL_SIZE_DEF,
  parameter int KEY_WIDTH = pll_pkg::KEY_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pll_pkg::in_t  in_data,
  input  wire pll_pkg::cmd_t cmd,
  output pll_pkg::stat_t     stat,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pll_pkg::out_t      out_data
);

  localparam int IDX_W = (POOL_SIZE > 2) ? $clog2(POOL_SIZE) : 1;
  localparam int KEY_W = (KEY_WIDTH < pll_pkg::ITEM_W) ? KEY_WIDTH : pll_pkg::ITEM_W;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(POOL_SIZE - 1);

  // list state
  logic [IDX_W-1:0]     head_r;
  logic [POOL_SIZE-1:0] used_r;
  logic [KEY_W-1:0]     val_mem [POOL_SIZE];
  logic [IDX_W-1:0]     link_mem [POOL_SIZE];

  // per request registers
  logic [KEY_W-1:0] key_r;
  logic [IDX_W-1:0] scan_r;
  logic [IDX_W-1:0] cur_r;
  logic [IDX_W-1:0] prev_r;
  logic [KEY_W-1:0] rd_val_r;
  logic [IDX_W-1:0] rd_link_r;
  logic [pll_pkg::STATUS_W-1:0] res_status_r;
  logic [IDX_W-1:0]             res_slot_r;
  pll_pkg::out_t out_r;
  logic          out_valid_r;

  logic [KEY_W-1:0] in_key;
  logic [IDX_W-1:0] rd_addr;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic [IDX_W-1:0] link_wdata;

  assign in_key  = in_data.item_value[KEY_W-1:0];
  assign rd_addr = cmd.load ? head_r : rd_link_r;

  // status back to the controller
  always_comb begin
    stat.in_op       = in_data.operation;
    stat.in_key_zero = (in_key == '0);
    stat.head_zero   = (head_r == '0);
    stat.scan_used   = used_r[scan_r];
    stat.scan_last   = (scan_r == LAST_SLOT);
    stat.match       = (rd_val_r == key_r);
    stat.link_zero   = (rd_link_r == '0);
    stat.out_free    = !out_valid_r || out_ready;
  end

  // link memory write port, shared by add and unlink
  always_comb begin
    link_we    = cmd.add_write || (cmd.unlink && (prev_r != '0));
    link_waddr = cmd.add_write ? scan_r : prev_r;
    link_wdata = cmd.add_write ? head_r : rd_link_r;
  end

  // slot memories: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.add_write) begin
      val_mem[scan_r] <= key_r;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd.load || cmd.walk_next) begin
      rd_val_r  <= val_mem[rd_addr];
      rd_link_r <= link_mem[rd_addr];
    end
  end

  // head and used bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      used_r <= '0;
    end else begin
      if (cmd.add_write) begin
        head_r         <= scan_r;
        used_r[scan_r] <= 1'b1;
      end
      if (cmd.unlink) begin
        used_r[cur_r] <= 1'b0;
        if (prev_r == '0) begin
          head_r <= rd_link_r;
        end
      end
    end
  end

  // request key, free slot scan and chain walk pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_key;
      scan_r <= IDX_W'(1);
      cur_r  <= head_r;
      prev_r <= '0;
    end
    if (cmd.scan_next) begin
      scan_r <= scan_r + IDX_W'(1);
    end
    if (cmd.walk_next) begin
      prev_r <= cur_r;
      cur_r  <= rd_link_r;
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      case (cmd.res_sel)
        pll_pkg::RES_SCAN: res_slot_r <= scan_r;
        pll_pkg::RES_CUR:  res_slot_r <= cur_r;
        default:           res_slot_r <= '0;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status     <= res_status_r;
      out_r.slot_index <= pll_pkg::SLOT_W'(res_slot_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### src/pll_ctrl.sv
// controller: sequences add scans, remove walks and result hand-off
// depends on pll_pkg; drives pll_datapath through cmd_t
`timescale 1ns / 1ps
`default_nettype none

module pll_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pll_pkg::stat_t stat,
  output pll_pkg::cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = pll_pkg::ST_NOT_FOUND;
    cmd.res_sel    = pll_pkg::RES_NONE;
    in_ready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_op == pll_pkg::OP_ADD) begin
            if (stat.in_key_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = pll_pkg::ST_ZERO;
              state_nxt      = S_EMIT;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (stat.head_zero) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = pll_pkg::ST_NOT_FOUND;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      // look for the lowest free slot, one per cycle
      S_SCAN: begin
        if (!stat.scan_used) begin
          cmd.add_write  = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = pll_pkg::ST_ADDED;
          cmd.res_sel    = pll_pkg::RES_SCAN;
          state_nxt      = S_EMIT;
        end else if (stat.scan_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = pll_pkg::ST_FULL;
          state_nxt      = S_EMIT;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      // compare one chain slot per cycle
      S_WALK: begin
        if (stat.match) begin
          cmd.unlink     = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = pll_pkg::ST_REMOVED;
          cmd.res_sel    = pll_pkg::RES_CUR;
          state_nxt      = S_EMIT;
        end else if (stat.link_zero) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = pll_pkg::ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end else begin
          cmd.walk_next = 1'b1;
        end
      end
      // hand the result over once the output register is free
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### src/pooled_linked_list.sv
// top level of the pooled linked list: controller plus datapath
// depends on pll_pkg, pll_ctrl and pll_datapath
`timescale 1ns / 1ps
`default_nettype none

// Keeps a singly linked list of nonzero keys in a pool of POOL_SIZE slots,
// slot 0 standing for the empty link. Each request gives one result. An add
// scans the used bits one slot per cycle up to the lowest free slot k (1 to
// POOL_SIZE-1); with no free slot the scan covers all POOL_SIZE-1 slots before
// full is reported. A zero key is refused without a scan. A remove compares
// the chain slots in turn, with one read of the slot memories per cycle. The
// last step of a request repeats while an earlier result still waits in the
// output register. One request is worked on at a time; a new one is taken
// while the previous result still waits in the output register. The used bits
// reset to all free; slot contents need no clearing.
module pooled_linked_list #(
  parameter int POOL_SIZE = pll_pkg::POOL_SIZE_DEF,
  parameter int KEY_WIDTH = pll_pkg::KEY_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire pll_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output pll_pkg::out_t     out_data
);

  pll_pkg::cmd_t  cmd;
  pll_pkg::stat_t stat;

  // sequencing
  pll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // list storage and result register
  pll_datapath #(
    .POOL_SIZE (POOL_SIZE),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
